/* hdl/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for barometric sensor compensation
// Sequencer states, arithmetic unit opcodes, register indexes and constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DATA_W     = 32;
    localparam int RAW_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_CNT_W = 5;   // one bit per cycle over DATA_W steps

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_C = 3'd4;

    // compensation constants
    localparam logic [DATA_W-1:0] K_B6_OFS   = 32'd4000;
    localparam logic [DATA_W-1:0] K_B4_OFS   = 32'd32768;
    localparam logic [DATA_W-1:0] K_B7_SCALE = 32'd50000;
    localparam logic [DATA_W-1:0] K_P_C1     = 32'd3038;
    localparam logic [DATA_W-1:0] K_P_C2     = 32'hFFFF_E343;  // -7357
    localparam logic [DATA_W-1:0] K_P_C3     = 32'd3791;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_DIV,
        ST_P_SQ,
        ST_P_X1,
        ST_P_B3,
        ST_P_X3,
        ST_P_X4,
        ST_P_B4,
        ST_P_B7,
        ST_P_DIV,
        ST_P_SQP,
        ST_P_K1,
        ST_P_K2,
        ST_FIN
    } state_t;

endpackage

/* hdl/barometric_sensor_compensation.sv */
`timescale 1ns / 1ps
// Pressure takes 10 multiplies and 1 divide and temperature 1 of each, all in
// the shared bit-serial unit; a zero divisor skips the remaining steps to ST_FIN.
// One item at a time: a new reading is not taken until the last one is through,
// and a result waiting at the output register holds the sequencer in ST_FIN.
// Reset: asynchronous active low; calibration registers, stored B5 term and control clear.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: BMP180 integer compensation
// Sequencer around one bit-serial multiply/divide unit; calibration registers
// and the B5 temperature term are held locally.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [bsc_pkg::RAW_W-1:0]     raw_reading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic signed [bsc_pkg::DATA_W-1:0] value,
    output logic                          divide_error,
    input  logic                          cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::DATA_W-1:0]    cfg_data
);
    import bsc_pkg::*;

    state_t            state_reg, state_next;
    logic              launched_reg, launched_next;
    logic [DATA_W-1:0] cta_reg, ctb_reg, cpa_reg, cpb_reg, cpc_reg;
    logic [DATA_W-1:0] b5_reg, b5_next;
    logic              kind_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [DATA_W-1:0] x1_reg, x1_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] b3_reg, b3_next;
    logic [DATA_W-1:0] b4_reg, b4_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              err_reg, err_next;
    logic              ov_reg, ov_next;
    logic              out_load;
    logic [DATA_W-1:0] ov_val_reg;
    logic              ov_err_reg;
    logic              ov_kind_reg;

    alu_op_t           alu_op;
    logic [DATA_W-1:0] alu_a, alu_b, alu_res;
    alu_stat_t         alu_stat;

    // calibration fields
    logic [DATA_W-1:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
    logic [DATA_W-1:0] raw32, b6, t_d, t_num, q_s, sum_t, ofs_b3, x4_sum, k_sum;
    logic              in_acc, launch, t_neg;

    assign ac5 = {16'd0, cta_reg[31:16]};
    assign ac6 = {16'd0, cta_reg[15:0]};
    assign mc  = {{16{ctb_reg[31]}}, ctb_reg[31:16]};
    assign md  = {{16{ctb_reg[15]}}, ctb_reg[15:0]};
    assign ac1 = {{16{cpa_reg[31]}}, cpa_reg[31:16]};
    assign ac2 = {{16{cpa_reg[15]}}, cpa_reg[15:0]};
    assign ac3 = {{16{cpb_reg[31]}}, cpb_reg[31:16]};
    assign ac4 = {16'd0, cpb_reg[15:0]};
    assign b1  = {{16{cpc_reg[31]}}, cpc_reg[31:16]};
    assign b2  = {{16{cpc_reg[15]}}, cpc_reg[15:0]};

    assign raw32  = {16'd0, raw_reg};
    assign b6     = b5_reg - K_B6_OFS;
    assign t_d    = x1_reg + md;
    assign t_num  = mc << 11;
    assign t_neg  = t_num[31] ^ t_d[31];
    assign q_s    = t_neg ? (32'd0 - alu_res) : alu_res;
    assign sum_t  = x1_reg + q_s;
    assign ofs_b3 = (ac1 << 2) + x1_reg + 32'($signed(alu_res) >>> 11) + 32'd2;
    assign x4_sum = x1_reg + 32'($signed(alu_res) >>> 16) + 32'd2;
    assign k_sum  = x1_reg + 32'($signed(alu_res) >>> 16) + K_P_C3;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign launch   = !launched_reg;

    bsc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (alu_op),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_res),
        .stat   (alu_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc) state_next = kind ? ST_P_SQ : ST_T_MUL;
            ST_T_MUL: if (alu_stat.done) state_next = ST_T_DIV;
            ST_T_DIV:
            begin
                if (t_d == '0 || alu_stat.done)
                    state_next = ST_FIN;
            end
            ST_P_SQ:  if (alu_stat.done) state_next = ST_P_X1;
            ST_P_X1:  if (alu_stat.done) state_next = ST_P_B3;
            ST_P_B3:  if (alu_stat.done) state_next = ST_P_X3;
            ST_P_X3:  if (alu_stat.done) state_next = ST_P_X4;
            ST_P_X4:  if (alu_stat.done) state_next = ST_P_B4;
            ST_P_B4:  if (alu_stat.done) state_next = ST_P_B7;
            ST_P_B7:
            begin
                if (b4_reg == '0)
                    state_next = ST_FIN;
                else if (alu_stat.done)
                    state_next = ST_P_DIV;
            end
            ST_P_DIV: if (alu_stat.done) state_next = ST_P_SQP;
            ST_P_SQP: if (alu_stat.done) state_next = ST_P_K1;
            ST_P_K1:  if (alu_stat.done) state_next = ST_P_K2;
            ST_P_K2:  if (alu_stat.done) state_next = ST_FIN;
            ST_FIN:   if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // unit launch, operand select and capture of each step
    always_comb
    begin
        alu_op        = ALU_NOP;
        alu_a         = '0;
        alu_b         = '0;
        launched_next = launched_reg;
        x1_next       = x1_reg;
        sq_next       = sq_reg;
        b3_next       = b3_reg;
        b4_next       = b4_reg;
        p_next        = p_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        b5_next       = b5_reg;
        ov_next       = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (alu_stat.done)
            launched_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                launched_next = 1'b0;
                err_next      = 1'b0;
                res_next      = '0;
            end
            ST_T_MUL:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = raw32 - ac6;
                alu_b  = ac5;
                if (alu_stat.done)
                    x1_next = 32'($signed(alu_res) >>> 15);
            end
            ST_T_DIV:
            begin
                if (t_d == '0)
                    err_next = 1'b1;
                else
                begin
                    alu_op = launch ? ALU_DIV : ALU_NOP;
                    alu_a  = t_num[31] ? (32'd0 - t_num) : t_num;
                    alu_b  = t_d[31] ? (32'd0 - t_d) : t_d;
                end
                if (alu_stat.done)
                begin
                    b5_next  = sum_t;
                    res_next = 32'($signed(sum_t + 32'd8) >>> 4);
                end
            end
            ST_P_SQ:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = b6;
                alu_b  = b6;
                if (alu_stat.done)
                    sq_next = 32'($signed(alu_res) >>> 12);
            end
            ST_P_X1:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = b2;
                alu_b  = sq_reg;
                if (alu_stat.done)
                    x1_next = 32'($signed(alu_res) >>> 11);
            end
            ST_P_B3:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = ac2;
                alu_b  = b6;
                if (alu_stat.done)
                    b3_next = 32'($signed(ofs_b3) >>> 2);
            end
            ST_P_X3:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = ac3;
                alu_b  = b6;
                if (alu_stat.done)
                    x1_next = 32'($signed(alu_res) >>> 13);
            end
            ST_P_X4:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = b1;
                alu_b  = sq_reg;
                if (alu_stat.done)
                    x1_next = 32'($signed(x4_sum) >>> 2);
            end
            ST_P_B4:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = ac4;
                alu_b  = x1_reg + K_B4_OFS;
                if (alu_stat.done)
                    b4_next = alu_res >> 15;
            end
            ST_P_B7:
            begin
                if (b4_reg == '0)
                    err_next = 1'b1;
                else
                begin
                    alu_op = launch ? ALU_MUL : ALU_NOP;
                    alu_a  = raw32 - b3_reg;
                    alu_b  = K_B7_SCALE;
                end
                if (alu_stat.done)
                    p_next = alu_res;
            end
            ST_P_DIV:
            begin
                // large B7 is divided first and doubled after
                alu_op = launch ? ALU_DIV : ALU_NOP;
                alu_a  = p_reg[31] ? p_reg : (p_reg << 1);
                alu_b  = b4_reg;
                if (alu_stat.done)
                    p_next = p_reg[31] ? (alu_res << 1) : alu_res;
            end
            ST_P_SQP:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = 32'($signed(p_reg) >>> 8);
                alu_b  = 32'($signed(p_reg) >>> 8);
                if (alu_stat.done)
                    x1_next = alu_res;
            end
            ST_P_K1:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = x1_reg;
                alu_b  = K_P_C1;
                if (alu_stat.done)
                    x1_next = 32'($signed(alu_res) >>> 16);
            end
            ST_P_K2:
            begin
                alu_op = launch ? ALU_MUL : ALU_NOP;
                alu_a  = K_P_C2;
                alu_b  = p_reg;
                if (alu_stat.done)
                    res_next = p_reg + 32'($signed(k_sum) >>> 4);
            end
            ST_FIN:
            begin
                if (!ov_reg || out_ready)
                    ov_next = 1'b1;
            end
            default:
            begin
                alu_op = ALU_NOP;
            end
        endcase
        if (alu_op != ALU_NOP)
            launched_next = 1'b1;
    end

    // control and stored state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
            ov_reg       <= 1'b0;
            b5_reg       <= '0;
            cta_reg      <= '0;
            ctb_reg      <= '0;
            cpa_reg      <= '0;
            cpb_reg      <= '0;
            cpc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            ov_reg       <= ov_next;
            b5_reg       <= b5_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP_A:  cta_reg <= cfg_data;
                    REG_TEMP_B:  ctb_reg <= cfg_data;
                    REG_PRESS_A: cpa_reg <= cfg_data;
                    REG_PRESS_B: cpb_reg <= cfg_data;
                    REG_PRESS_C: cpc_reg <= cfg_data;
                    default:     cta_reg <= cta_reg;
                endcase
            end
        end
    end

    // working registers and output payload
    assign out_load = (state_reg == ST_FIN) && (!ov_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= kind;
            raw_reg  <= raw_reading;
        end
        x1_reg  <= x1_next;
        sq_reg  <= sq_next;
        b3_reg  <= b3_next;
        b4_reg  <= b4_next;
        p_reg   <= p_next;
        res_reg <= res_next;
        err_reg <= err_next;
        if (out_load)
        begin
            ov_val_reg  <= err_reg ? '0 : res_reg;
            ov_err_reg  <= err_reg;
            ov_kind_reg <= kind_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign result_kind  = ov_kind_reg;
    assign value        = ov_val_reg;
    assign divide_error = ov_err_reg;

`ifndef SYNTHESIS
    // the arithmetic unit is quiet whenever a new reading can be taken
    a_idle_alu: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !alu_stat.busy)
        else $error("arithmetic unit busy while idle");

    // a finished step never lands outside a compute state
    a_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> (state_reg != ST_IDLE && state_reg != ST_FIN))
        else $error("unit result with no consumer");

    // a taken reading starts a computation
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != ST_IDLE)
        else $error("reading accepted but sequencer idle");

    // a result is only loaded when the output register is free or drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(ov_val_reg)))
        else $error("pending result overwritten");
`endif

endmodule

/* hdl/bsc_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_alu: bit-serial multiply and divide unit
// Shift-add 32x32 multiply (low word) or restoring unsigned 32/32 divide,
// one bit per cycle; done pulses as the last step's result is registered.
// ----------------------------------------------------------------------------
module bsc_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsc_pkg::alu_op_t           op,
    input  logic [bsc_pkg::DATA_W-1:0] opa,
    input  logic [bsc_pkg::DATA_W-1:0] opb,
    output logic [bsc_pkg::DATA_W-1:0] result,
    output bsc_pkg::alu_stat_t         stat
);
    import bsc_pkg::*;

    logic [DATA_W-1:0]     acc_reg, acc_next;
    logic [DATA_W-1:0]     sa_reg, sa_next;
    logic [DATA_W-1:0]     sb_reg, sb_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    alu_op_t               op_reg, op_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_W:0]       rem_sh;
    logic [DATA_W:0]       rem_sub;

    // one step of the selected operation
    always_comb
    begin
        rem_sh    = {acc_reg, sa_reg[DATA_W-1]};
        rem_sub   = rem_sh - {1'b0, sb_reg};
        acc_next  = acc_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (!busy_reg && op != ALU_NOP)
        begin
            acc_next  = '0;
            sa_next   = opa;
            sb_next   = opb;
            cnt_next  = '0;
            op_next   = op;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    acc_next = acc_reg + (sb_reg[0] ? sa_reg : '0);
                    sa_next  = {sa_reg[DATA_W-2:0], 1'b0};
                    sb_next  = {1'b0, sb_reg[DATA_W-1:1]};
                end
                ALU_DIV:
                begin
                    if (!rem_sub[DATA_W])
                    begin
                        acc_next = rem_sub[DATA_W-1:0];
                        sa_next  = {sa_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh[DATA_W-1:0];
                        sa_next  = {sa_reg[DATA_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_NOP;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
    end

    assign result    = (op_reg == ALU_DIV) ? sa_reg : acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
